// File: hdl/sgma_pkg.sv
package sgma_pkg;

    localparam int MaxWidthDefault = 4096;
    localparam int MaxHeight = 4096;
    localparam int CordicSteps = 16;
    localparam int GradW = 11;
    localparam int AbsW = 10;
    localparam int SqW = 21;
    localparam int MagW = SqW;
    localparam int CorW = 30;
    localparam int ZW = 19;
    localparam int PiQ16 = 205887;
    localparam int HalfPiQ16 = 102944;

    localparam logic [1:0] RegWidth = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;

    typedef struct packed {
        logic valid;
        logic last;
        logic gx_neg;
        logic gy_neg;
        logic [7:0] ax_sat;
        logic [7:0] ay_sat;
        logic [AbsW-1:0] ax;
        logic [AbsW-1:0] ay;
    } grad_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic gx_neg;
        logic gy_neg;
        logic special;
        logic [ZW-1:0] special_z;
        logic [7:0] ax_sat;
        logic [7:0] ay_sat;
        logic [SqW-1:0] rem;
        logic [MagW-1:0] root;
        logic signed [CorW-1:0] x;
        logic signed [CorW-1:0] y;
        logic signed [ZW:0] z;
    } cell_t;

    function automatic logic [ZW:0] atan_q16(input logic [4:0] i);
        logic [ZW:0] v;
        unique case (i)
            5'd0: v = 20'd51472;
            5'd1: v = 20'd30385;
            5'd2: v = 20'd16055;
            5'd3: v = 20'd8150;
            5'd4: v = 20'd4091;
            5'd5: v = 20'd2047;
            5'd6: v = 20'd1024;
            5'd7: v = 20'd512;
            5'd8: v = 20'd256;
            5'd9: v = 20'd128;
            5'd10: v = 20'd64;
            5'd11: v = 20'd32;
            5'd12: v = 20'd16;
            5'd13: v = 20'd8;
            5'd14: v = 20'd4;
            5'd15: v = 20'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/sgma_ram.sv
module sgma_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/sgma_cell.sv
module sgma_cell #(
    parameter int Step = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  sgma_pkg::cell_t   cell_in,
    output sgma_pkg::cell_t   cell_out
);

    localparam logic [4:0] StepIdx = 5'(Step);
    localparam logic [sgma_pkg::SqW-1:0] Bit =
        (Step <= 10) ? sgma_pkg::SqW'(1) << (2 * (10 - Step)) : '0;

    sgma_pkg::cell_t cell_reg;
    sgma_pkg::cell_t cell_next;

    always_comb begin
        logic signed [sgma_pkg::CorW-1:0] dx;
        logic signed [sgma_pkg::CorW-1:0] dy;
        logic [sgma_pkg::SqW-1:0] trial;
        cell_next = cell_in;
        trial = '0;
        dx = cell_in.y >>> StepIdx;
        dy = cell_in.x >>> StepIdx;
        if (!cell_in.y[sgma_pkg::CorW-1]) begin
            cell_next.x = cell_in.x + dx;
            cell_next.y = cell_in.y - dy;
            cell_next.z = cell_in.z + sgma_pkg::atan_q16(StepIdx);
        end else begin
            cell_next.x = cell_in.x - dx;
            cell_next.y = cell_in.y + dy;
            cell_next.z = cell_in.z - sgma_pkg::atan_q16(StepIdx);
        end
        if (Step <= 10) begin
            trial = sgma_pkg::SqW'(cell_in.root) + Bit;
            if (cell_in.rem >= trial) begin
                cell_next.rem = cell_in.rem - trial;
                cell_next.root = sgma_pkg::MagW'((sgma_pkg::SqW'(cell_in.root) >> 1) + Bit);
            end else begin
                cell_next.root = cell_in.root >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (advance) begin
            cell_reg.valid <= cell_next.valid;
        end
        if (advance) begin
            cell_reg.last <= cell_next.last;
            cell_reg.gx_neg <= cell_next.gx_neg;
            cell_reg.gy_neg <= cell_next.gy_neg;
            cell_reg.special <= cell_next.special;
            cell_reg.special_z <= cell_next.special_z;
            cell_reg.ax_sat <= cell_next.ax_sat;
            cell_reg.ay_sat <= cell_next.ay_sat;
            cell_reg.rem <= cell_next.rem;
            cell_reg.root <= cell_next.root;
            cell_reg.x <= cell_next.x;
            cell_reg.y <= cell_next.y;
            cell_reg.z <= cell_next.z;
        end
    end

    assign cell_out = cell_reg;

endmodule

// File: hdl/sgma_window.sv
module sgma_window #(
    parameter int MaxWidth = sgma_pkg::MaxWidthDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              take,
    input  logic [7:0]        pixel,
    input  logic [12:0]       image_width,
    input  logic [12:0]       image_height,
    output sgma_pkg::grad_t   grad
);

    localparam int AW = $clog2(MaxWidth);

    logic [11:0] col_reg, col_next, row_reg, row_next;
    logic [12:0] w_used, h_used;
    logic [AW-1:0] addr, raddr;
    logic [7:0] upper_q, middle_q;
    logic emit, last;
    logic [7:0] win_reg [6];
    logic signed [sgma_pkg::GradW-1:0] gx, gy;
    logic [sgma_pkg::AbsW-1:0] ax, ay;
    sgma_pkg::grad_t grad_reg;

    always_comb begin
        if (image_width < 13'd3) w_used = 13'd3;
        else if (image_width > 13'(MaxWidth)) w_used = 13'(MaxWidth);
        else w_used = image_width;
        if (image_height < 13'd3) h_used = 13'd3;
        else if (image_height > 13'(sgma_pkg::MaxHeight)) h_used = 13'(sgma_pkg::MaxHeight);
        else h_used = image_height;
    end

    // The stores are read one column ahead so the outputs always show the current column.
    assign addr = AW'(col_reg);
    assign raddr = take ? AW'(col_next) : addr;

    always_comb begin
        logic [12:0] c1;
        c1 = {1'b0, col_reg} + 13'd1;
        col_next = col_reg + 12'd1;
        row_next = row_reg;
        if (c1 >= w_used) begin
            col_next = '0;
            if ({1'b0, row_reg} + 13'd1 >= h_used) row_next = '0;
            else row_next = row_reg + 12'd1;
        end else if ({1'b0, row_reg} >= h_used) begin
            row_next = '0;
        end
    end

    sgma_ram #(.Width(8), .Depth(MaxWidth)) u_upper (
        .aclk(aclk), .we(take), .waddr(addr), .wdata(middle_q),
        .raddr(raddr), .rdata(upper_q)
    );

    sgma_ram #(.Width(8), .Depth(MaxWidth)) u_middle (
        .aclk(aclk), .we(take), .waddr(addr), .wdata(pixel),
        .raddr(raddr), .rdata(middle_q)
    );

    always_comb begin
        gy = $signed({3'b0, upper_q}) + $signed({2'b0, middle_q, 1'b0})
            + $signed({3'b0, pixel}) - $signed({3'b0, win_reg[0]})
            - $signed({2'b0, win_reg[1], 1'b0}) - $signed({3'b0, win_reg[2]});
        gx = $signed({3'b0, win_reg[0]}) + $signed({2'b0, win_reg[3], 1'b0})
            + $signed({3'b0, upper_q}) - $signed({3'b0, win_reg[2]})
            - $signed({2'b0, win_reg[5], 1'b0}) - $signed({3'b0, pixel});
        ax = gx[sgma_pkg::GradW-1] ? sgma_pkg::AbsW'(-gx) : sgma_pkg::AbsW'(gx);
        ay = gy[sgma_pkg::GradW-1] ? sgma_pkg::AbsW'(-gy) : sgma_pkg::AbsW'(gy);
        emit = (col_reg >= 12'd2) && (row_reg >= 12'd2);
        last = ({1'b0, col_reg} + 13'd1 == w_used) && ({1'b0, row_reg} + 13'd1 == h_used);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            grad_reg.valid <= 1'b0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end else begin
            if (take) begin
                col_reg <= col_next;
                row_reg <= row_next;
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= upper_q;
                win_reg[4] <= middle_q;
                win_reg[5] <= pixel;
            end
            if (advance) begin
                grad_reg.valid <= take && emit;
            end
        end
        if (advance) begin
            grad_reg.last <= last;
            grad_reg.gx_neg <= gx[sgma_pkg::GradW-1];
            grad_reg.gy_neg <= gy[sgma_pkg::GradW-1];
            grad_reg.ax <= ax;
            grad_reg.ay <= ay;
            grad_reg.ax_sat <= (ax > 10'd255) ? 8'd255 : ax[7:0];
            grad_reg.ay_sat <= (ay > 10'd255) ? 8'd255 : ay[7:0];
        end
    end

    assign grad = grad_reg;

endmodule

// File: hdl/sobel_gradient_magnitude_angle.sv
// Throughput: one pixel per cycle while the output is not stalled; line stores, the window, a
// chain of 16 cells and two final stages all advance together, one CORDIC step per cell and a
// square-root step in the first 11.
// A stalled output halts the whole chain; m_tdata holds until taken.
// Reset clears counters, window and valid flags; width and height return to 640 and 480.
module sobel_gradient_magnitude_angle #(
    parameter int MAX_WIDTH = sgma_pkg::MaxWidthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // grad_x_abs, grad_y_abs, magnitude, angle, 7 zero bits
    output logic        m_tlast,   // last_of_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = sgma_pkg::CordicSteps;

    logic [12:0] width_reg, height_reg;
    logic advance, take;
    sgma_pkg::grad_t grad;
    sgma_pkg::cell_t head;
    sgma_pkg::cell_t chain [N];
    logic fin_valid_reg, fin_last_reg, fin_gy_neg_reg;
    logic [10:0] fin_q_reg;
    logic [7:0] fin_ax_reg, fin_ay_reg, fin_mag_reg;
    logic out_valid_reg;
    logic [39:0] out_data_reg;
    logic out_last_reg;
    logic [sgma_pkg::ZW-1:0] a, full;
    logic [29:0] prod;
    logic [23:0] tprod;
    logic [8:0] t, ang;
    logic [7:0] mag;

    assign pready = 1'b1;
    assign advance = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign take = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 13'd640;
            height_reg <= 13'd480;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == sgma_pkg::RegWidth[0]) width_reg <= pwdata[12:0];
            else height_reg <= pwdata[12:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == sgma_pkg::RegWidth[0]) prdata[12:0] = width_reg;
        else prdata[12:0] = height_reg;
    end

    sgma_window #(.MaxWidth(MAX_WIDTH)) u_window (
        .aclk(aclk), .aresetn(aresetn), .advance(advance), .take(take),
        .pixel(s_tdata), .image_width(width_reg), .image_height(height_reg), .grad(grad)
    );

    always_comb begin
        head = '0;
        head.valid = grad.valid;
        head.last = grad.last;
        head.gx_neg = grad.gx_neg;
        head.gy_neg = grad.gy_neg;
        head.ax_sat = grad.ax_sat;
        head.ay_sat = grad.ay_sat;
        head.rem = sgma_pkg::SqW'(grad.ax) * sgma_pkg::SqW'(grad.ax)
            + sgma_pkg::SqW'(grad.ay) * sgma_pkg::SqW'(grad.ay);
        head.x = sgma_pkg::CorW'({grad.ax, 16'b0});
        head.y = sgma_pkg::CorW'({grad.ay, 16'b0});
        head.special = (grad.ay == '0) || (grad.ax == '0);
        head.special_z = (grad.ay == '0) ? '0 : sgma_pkg::ZW'(sgma_pkg::HalfPiQ16);
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == 0) begin : g_head
            sgma_cell #(.Step(i)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .advance(advance),
                .cell_in(head), .cell_out(chain[i])
            );
        end else begin : g_body
            sgma_cell #(.Step(i)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .advance(advance),
                .cell_in(chain[i-1]), .cell_out(chain[i])
            );
        end
    end

    // The angle in degrees is floor(full * 573 / 2^16 / 10), or 360 minus a nonzero such value when gy
    // is negative; the division by ten uses a reciprocal multiplication that is exact below 16384.
    always_comb begin
        if (chain[N-1].special) a = chain[N-1].special_z;
        else if (chain[N-1].z[sgma_pkg::ZW]) a = '0;
        else if (chain[N-1].z[sgma_pkg::ZW-1:0] > sgma_pkg::ZW'(sgma_pkg::HalfPiQ16))
            a = sgma_pkg::ZW'(sgma_pkg::HalfPiQ16);
        else a = chain[N-1].z[sgma_pkg::ZW-1:0];
        full = chain[N-1].gx_neg ? sgma_pkg::ZW'(sgma_pkg::PiQ16) - a : a;
        prod = 30'(full) * 30'd573;
        mag = (chain[N-1].root > sgma_pkg::MagW'(255)) ? 8'd255 : chain[N-1].root[7:0];
        tprod = 24'(fin_q_reg) * 24'd6554;
        t = 9'(tprod >> 16);
        if (!fin_gy_neg_reg || t == 9'd0) ang = t;
        else ang = 9'd360 - t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            fin_valid_reg <= chain[N-1].valid;
            out_valid_reg <= fin_valid_reg;
        end
        if (advance) begin
            fin_q_reg <= prod[26:16];
            fin_gy_neg_reg <= chain[N-1].gy_neg;
            fin_last_reg <= chain[N-1].last;
            fin_ax_reg <= chain[N-1].ax_sat;
            fin_ay_reg <= chain[N-1].ay_sat;
            fin_mag_reg <= mag;
            out_data_reg <= {7'b0, ang, fin_mag_reg, fin_ay_reg, fin_ax_reg};
            out_last_reg <= fin_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[32:24] < 9'd360)
        else $error("angle out of range");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

// File: verif/sobel_gradient_magnitude_angle_tb.sv
module sobel_gradient_magnitude_angle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;
    localparam int DrainCycles = 30;
    localparam int StoreDepth = sgma_pkg::MaxWidthDefault;

    typedef struct {
        logic [7:0] gx_abs;
        logic [7:0] gy_abs;
        logic [7:0] mag;
        logic [8:0] ang;
        logic       last;
    } grad_item_t;

    typedef struct {
        logic [7:0] pix [9];
        grad_item_t result;
    } frame_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // pixel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // grad_x_abs, grad_y_abs, magnitude, angle, 7 zero bits
    logic        m_tlast;          // last_of_frame
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sobel_gradient_magnitude_angle DUT (.*);

    always #5 aclk = ~aclk;

    // Predictor state.
    logic [7:0]  upper_row [StoreDepth];
    logic [7:0]  middle_row [StoreDepth];
    logic [7:0]  win [6];
    int          col_pos;
    int          row_pos;
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    grad_item_t  pending_grads [$];
    int          fails = 0;
    int          pixels_sent = 0;
    int          grads_seen = 0;
    int          frames_sent = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;

    function automatic int clamp_dim(input logic [12:0] v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint floor_root(input longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic longint quadrant_angle(input longint ax, input longint ay);
        longint x, y, z, dx, dy;
        longint steps [sgma_pkg::CordicSteps] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
                                                   512, 256, 128, 64, 32, 16, 8, 4, 2};
        if (ay == 0) return 0;
        if (ax == 0) return sgma_pkg::HalfPiQ16;
        x = ax <<< 16;
        y = ay <<< 16;
        z = 0;
        for (int i = 0; i < sgma_pkg::CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += steps[i];
            end else begin
                x -= dx; y += dy; z -= steps[i];
            end
        end
        if (z < 0) z = 0;
        if (z > sgma_pkg::HalfPiQ16) z = sgma_pkg::HalfPiQ16;
        return z;
    endfunction

    function automatic bit predict_gradient(input logic [7:0] pix, output grad_item_t g);
        int w, h, c, r;
        longint u, m, p, gx, gy, ax, ay, full, t;
        bit fires;
        w = clamp_dim(width_reg, StoreDepth);
        h = clamp_dim(height_reg, sgma_pkg::MaxHeight);
        c = col_pos % StoreDepth;
        r = row_pos;
        u = upper_row[c];
        m = middle_row[c];
        p = pix;
        fires = (c >= 2 && r >= 2);
        gy = u + 2 * m + p - win[0] - 2 * win[1] - win[2];
        gx = win[0] + 2 * win[3] + u - win[2] - 2 * win[5] - p;
        g.last = (c + 1 == w && r + 1 == h);
        upper_row[c] = m[7:0];
        middle_row[c] = pix;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = u[7:0];
        win[4] = m[7:0];
        win[5] = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end else if (r >= h) begin
            r = 0;
        end
        col_pos = c;
        row_pos = r;
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        g.gx_abs = ax > 255 ? 8'd255 : ax[7:0];
        g.gy_abs = ay > 255 ? 8'd255 : ay[7:0];
        m = floor_root(ax * ax + ay * ay);
        g.mag = m > 255 ? 8'd255 : m[7:0];
        full = quadrant_angle(ax, ay);
        if (gx < 0) full = sgma_pkg::PiQ16 - full;
        t = (full * 573) / 655360;
        g.ang = gy >= 0 ? 9'(t % 360) : 9'((360 - t) % 360);
        return fires;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00};
        pwdata <= {19'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == sgma_pkg::RegWidth) width_reg = value;
        else if (idx == sgma_pkg::RegHeight) height_reg = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] pix, input bit typed, input grad_item_t want);
        grad_item_t g;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        if (predict_gradient(pix, g)) pending_grads.push_back(typed ? want : g);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_grads.size() != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    task automatic send_frame(input int w, input int h);
        grad_item_t none;
        int base, spread;
        none = '{default: '0};
        base = $urandom_range(0, 255);
        spread = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 256;
        for (int i = 0; i < w * h; i++) begin
            if (spread == 256) send_pixel(8'($urandom_range(0, 255)), 0, none);
            else send_pixel(8'(base + $urandom_range(0, spread)), 0, none);
        end
        frames_sent++;
    endtask

    // Directed 3x3 frames: flat, bright top row, bright left column.
    frame_row_t frame_tab [3] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, '{8'd0, 8'd0, 8'd0, 9'd0, 1'b1}},
        '{'{255, 255, 255, 0, 0, 0, 0, 0, 0}, '{8'd255, 8'd0, 8'd255, 9'd0, 1'b1}},
        '{'{255, 0, 0, 255, 0, 0, 255, 0, 0}, '{8'd0, 8'd255, 8'd255, 9'd270, 1'b1}}
    };

    always @(posedge aclk) begin
        grad_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            grads_seen++;
            if (pending_grads.size() == 0) begin
                $error("unexpected item: data %h last %b", m_tdata, m_tlast);
                fails++;
            end else begin
                want = pending_grads.pop_front();
                if (m_tdata[7:0] !== want.gx_abs) begin
                    $error("grad_x_abs: expected %0d, got %0d", want.gx_abs, m_tdata[7:0]);
                    fails++;
                end
                if (m_tdata[15:8] !== want.gy_abs) begin
                    $error("grad_y_abs: expected %0d, got %0d", want.gy_abs, m_tdata[15:8]);
                    fails++;
                end
                if (m_tdata[23:16] !== want.mag) begin
                    $error("magnitude: expected %0d, got %0d", want.mag, m_tdata[23:16]);
                    fails++;
                end
                if (m_tdata[32:24] !== want.ang) begin
                    $error("angle: expected %0d, got %0d", want.ang, m_tdata[32:24]);
                    fails++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_frame: expected %b, got %b", want.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        int mode_left, mode;
        if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left <= 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        int idle;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle = 0;
        else idle++;
        if (idle >= IdleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int w, h, start;
        foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        win = '{default: '0};
        col_pos = 0;
        row_pos = 0;
        width_reg = 13'd640;
        height_reg = 13'd480;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        write_reg(sgma_pkg::RegWidth, 13'd2);
        write_reg(sgma_pkg::RegHeight, 13'd1);
        foreach (frame_tab[f]) begin
            for (int i = 0; i < 9; i++) begin
                send_pixel(frame_tab[f].pix[i], i == 8, frame_tab[f].result);
            end
        end
        drain();

        write_reg(sgma_pkg::RegWidth, 13'd0);
        write_reg(sgma_pkg::RegHeight, 13'd8191);
        send_frame(3, 16);
        drain();
        write_reg(sgma_pkg::RegHeight, 13'd17);
        send_frame(3, 1);
        drain();

        start = pixels_sent;
        while (pixels_sent - start < 1250) begin
            w = $urandom_range(0, 3) == 0 ? 3 : $urandom_range(3, 20);
            h = $urandom_range(3, 8);
            write_reg(sgma_pkg::RegWidth, 13'(w));
            write_reg(sgma_pkg::RegHeight, 13'(h));
            repeat ($urandom_range(1, 2)) begin
                if (!hold_done && pixels_sent - start >= 300) begin
                    hold_req = 1;
                    hold_done = 1;
                end
                send_frame(w, h);
            end
            drain();
        end

        $display("Sent %0d pixels in %0d frames, checked %0d gradient items.",
                 pixels_sent, frames_sent, grads_seen);
        $display("Frames ranged from 3x3 up to 20 wide, with clamped registers, a height change "
                 + "inside a frame and output stalls.");
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
